// ===== hdl/rcsd_pkg.sv =====
// Package for the stick-command decoder: request and result structs, axis,
// gesture, gate and register codes, and the gesture table lookup.
// No dependencies; every other file in hdl/ imports it.
package rcsd_pkg;

	localparam int ValueW   = 12;
	localparam int TimeW    = 32;
	localparam int DelayW   = 16;
	localparam int CountW   = 8;
	localparam int PatternW = 8;
	localparam int CodeW    = 5;
	localparam int NumAxes  = 4;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;

	localparam logic [CountW-1:0] HOLD_MAX     = 8'd250;
	localparam logic [CountW-1:0] GESTURE_HOLD = 8'd20;
	localparam logic [CountW-1:0] TRIM_HOLD    = 8'd10;
	localparam logic [TimeW-1:0]  TICK_MS      = 32'd20;

	localparam logic [ValueW-1:0] LOW_THRESHOLD_RST  = 12'd1100;
	localparam logic [ValueW-1:0] HIGH_THRESHOLD_RST = 12'd1900;
	localparam logic [DelayW-1:0] DISARM_DELAY_RST   = 16'd250;

	typedef enum logic [1:0] {
		AX_NONE = 2'b00,
		AX_LO   = 2'b01,
		AX_HI   = 2'b10,
		AX_CE   = 2'b11
	} axis_class_t;

	typedef enum logic [CodeW-1:0] {
		GC_NONE          = 5'd0,
		GC_GYRO_CAL      = 5'd1,
		GC_WP_SAVE       = 5'd2,
		GC_WP_LOAD       = 5'd3,
		GC_MISSION_NEXT  = 5'd4,
		GC_MISSION_PREV  = 5'd5,
		GC_WP_RESET      = 5'd6,
		GC_CFG_PROFILE1  = 5'd7,
		GC_CFG_PROFILE2  = 5'd8,
		GC_CFG_PROFILE3  = 5'd9,
		GC_BAT_PROFILE1  = 5'd10,
		GC_BAT_PROFILE2  = 5'd11,
		GC_BAT_PROFILE3  = 5'd12,
		GC_SAVE          = 5'd13,
		GC_ACC_CAL       = 5'd14,
		GC_MAG_CAL       = 5'd15,
		GC_TRIM_PITCH_HI = 5'd16,
		GC_TRIM_PITCH_LO = 5'd17,
		GC_TRIM_ROLL_HI  = 5'd18,
		GC_TRIM_ROLL_LO  = 5'd19
	} gesture_code_t;

	typedef enum logic [1:0] {
		GATE_NONE    = 2'd0,
		GATE_WP      = 2'd1,
		GATE_MISSION = 2'd2,
		GATE_PROFILE = 2'd3
	} gate_t;

	typedef enum logic [1:0] {
		HOLD_KEEP  = 2'd0,
		HOLD_CLEAR = 2'd1,
		HOLD_TEN   = 2'd2
	} hold_action_t;

	typedef enum logic [2:0] {
		REG_LOW_THRESHOLD  = 3'd0,
		REG_HIGH_THRESHOLD = 3'd1,
		REG_DISARM_DELAY   = 3'd2,
		REG_DISARM_ANY_THR = 3'd3,
		REG_AUTO_ARM       = 3'd4,
		REG_PROFILE_EN     = 3'd5,
		REG_WAYPOINT_EN    = 3'd6,
		REG_MISSION_EN     = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [ValueW-1:0] roll_value;
		logic [ValueW-1:0] pitch_value;
		logic [ValueW-1:0] yaw_value;
		logic [ValueW-1:0] throttle_value;
		logic [TimeW-1:0]  now_ms;
		logic              throttle_at_low;
		logic              arm_switch_on;
		logic              link_trusted;
		logic              is_armed;
		logic              menu_active;
		logic              plane_motorstop;
	} stick_req_t;

	typedef struct packed {
		logic [PatternW-1:0] stick_pattern;
		logic                arm_request;
		logic                disarm_request;
		logic [CodeW-1:0]    gesture_code;
	} decode_rsp_t;

	typedef struct packed {
		logic profile_en;
		logic waypoint_en;
		logic mission_en;
	} gesture_enables_t;

	typedef struct packed {
		gesture_code_t code;
		gate_t         gate;
		hold_action_t  hold;
	} gesture_entry_t;

	typedef struct packed {
		logic          hit;
		gesture_code_t code;
		hold_action_t  hold;
	} gesture_hit_t;

	function automatic logic [PatternW-1:0] pat(axis_class_t thr, axis_class_t yaw,
			axis_class_t pitch, axis_class_t roll);
		return {thr, yaw, pitch, roll};
	endfunction

	// Gesture table: throttle, yaw, pitch, roll.
	function automatic gesture_entry_t gesture_lookup(logic [PatternW-1:0] pattern);
		gesture_entry_t e;
		e = '{code: GC_NONE, gate: GATE_NONE, hold: HOLD_KEEP};
		unique case (pattern)
			pat(AX_LO, AX_LO, AX_LO, AX_CE): e = '{GC_GYRO_CAL, GATE_NONE, HOLD_KEEP};
			pat(AX_LO, AX_CE, AX_HI, AX_LO): e = '{GC_WP_SAVE, GATE_WP, HOLD_KEEP};
			pat(AX_LO, AX_CE, AX_HI, AX_HI): e = '{GC_WP_LOAD, GATE_WP, HOLD_KEEP};
			pat(AX_LO, AX_CE, AX_CE, AX_HI): e = '{GC_MISSION_NEXT, GATE_MISSION, HOLD_CLEAR};
			pat(AX_LO, AX_CE, AX_CE, AX_LO): e = '{GC_MISSION_PREV, GATE_MISSION, HOLD_CLEAR};
			pat(AX_LO, AX_CE, AX_LO, AX_HI): e = '{GC_WP_RESET, GATE_WP, HOLD_KEEP};
			pat(AX_LO, AX_LO, AX_CE, AX_LO): e = '{GC_CFG_PROFILE1, GATE_PROFILE, HOLD_KEEP};
			pat(AX_LO, AX_LO, AX_HI, AX_CE): e = '{GC_CFG_PROFILE2, GATE_PROFILE, HOLD_KEEP};
			pat(AX_LO, AX_LO, AX_CE, AX_HI): e = '{GC_CFG_PROFILE3, GATE_PROFILE, HOLD_KEEP};
			pat(AX_HI, AX_LO, AX_CE, AX_LO): e = '{GC_BAT_PROFILE1, GATE_PROFILE, HOLD_KEEP};
			pat(AX_HI, AX_LO, AX_HI, AX_CE): e = '{GC_BAT_PROFILE2, GATE_PROFILE, HOLD_KEEP};
			pat(AX_HI, AX_LO, AX_CE, AX_HI): e = '{GC_BAT_PROFILE3, GATE_PROFILE, HOLD_KEEP};
			pat(AX_LO, AX_LO, AX_LO, AX_HI): e = '{GC_SAVE, GATE_NONE, HOLD_KEEP};
			pat(AX_HI, AX_LO, AX_LO, AX_CE): e = '{GC_ACC_CAL, GATE_NONE, HOLD_KEEP};
			pat(AX_HI, AX_HI, AX_LO, AX_CE): e = '{GC_MAG_CAL, GATE_NONE, HOLD_KEEP};
			pat(AX_HI, AX_CE, AX_HI, AX_CE): e = '{GC_TRIM_PITCH_HI, GATE_NONE, HOLD_TEN};
			pat(AX_HI, AX_CE, AX_LO, AX_CE): e = '{GC_TRIM_PITCH_LO, GATE_NONE, HOLD_TEN};
			pat(AX_HI, AX_CE, AX_CE, AX_HI): e = '{GC_TRIM_ROLL_HI, GATE_NONE, HOLD_TEN};
			pat(AX_HI, AX_CE, AX_CE, AX_LO): e = '{GC_TRIM_ROLL_LO, GATE_NONE, HOLD_TEN};
			default: e = '{code: GC_NONE, gate: GATE_NONE, hold: HOLD_KEEP};
		endcase
		return e;
	endfunction

endpackage

// ===== hdl/rc_stick_command_decoder.sv =====
// Top level of the stick-command decoder: configuration registers, the
// request and result handshakes, hold counter and arm/disarm logic.
// Depends on rcsd_pkg, rcsd_axis_lane and rcsd_gesture_merge.
//
//   Channel   Direction  Handshake                       Payload
//   stick     in         stick_valid / stick_stall       stick_data (stick_req_t)
//   decode    out        decode_valid / decode_stall     decode_data (decode_rsp_t)
//   config    in         APB write, psel&penable&pwrite  pwdata, register 4*i
//
// Each request is registered in stage one, then in the output register, and a new
// request can be taken every cycle unless stalled. Stage one is the four axis
// lanes; stage two merges them, updates the hold counter and disarm mark, and
// fills the output register. Reset restores the configuration defaults and clears
// all state. A stall on the result side holds the output register and backs up
// into stage one, and the request side sees stall only once both stages are full.
module rc_stick_command_decoder
	import rcsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             stick_valid,
	output logic             stick_stall,
	input  stick_req_t       stick_data,
	output logic             decode_valid,
	input  logic             decode_stall,
	output decode_rsp_t      decode_data,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	// Configuration registers.
	logic [ValueW-1:0] low_threshold_q;
	logic [ValueW-1:0] high_threshold_q;
	logic [DelayW-1:0] disarm_delay_q;
	logic              disarm_any_thr_q;
	logic              auto_arm_q;
	logic              profile_en_q;
	logic              waypoint_en_q;
	logic              mission_en_q;

	reg_index_t        reg_sel;
	logic              cfg_write;

	// Pipeline control and state.
	logic              valid_s1;
	logic              out_valid_q;
	logic              out_free;
	logic              s1_free;
	logic              process;
	stick_req_t        req_s1;
	logic [1:0]        axis_s1 [NumAxes];
	logic [ValueW-1:0] lane_value [NumAxes];

	logic [PatternW-1:0] prev_pattern_q;
	logic [CountW-1:0]   hold_count_q;
	logic [TimeW-1:0]    last_tick_q;
	logic [TimeW-1:0]    disarm_mark_q;

	logic [PatternW-1:0] pattern;
	gesture_hit_t        match;
	gesture_enables_t    enables;

	logic [TimeW-1:0]    tick_elapsed;
	logic [TimeW-1:0]    disarm_elapsed;
	logic                tick_due;
	logic                same_pattern;
	logic [CountW-1:0]   hold_mid;
	logic                take_tick;
	logic                auto_arm_mode;
	logic                arm_req;
	logic                disarm_req;
	logic                skip;
	logic                refresh_mark;
	logic                gesture_fire;
	logic [CountW-1:0]   hold_next;
	decode_rsp_t         rsp_d;

	// ---------------- Configuration port ----------------
	assign pready    = 1'b1;
	assign reg_sel   = reg_index_t'(paddr[AddrW-1:2]);
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q  <= LOW_THRESHOLD_RST;
			high_threshold_q <= HIGH_THRESHOLD_RST;
			disarm_delay_q   <= DISARM_DELAY_RST;
			disarm_any_thr_q <= 1'b1;
			auto_arm_q       <= 1'b0;
			profile_en_q     <= 1'b0;
			waypoint_en_q    <= 1'b1;
			mission_en_q     <= 1'b1;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_LOW_THRESHOLD:  low_threshold_q  <= pwdata[ValueW-1:0];
				REG_HIGH_THRESHOLD: high_threshold_q <= pwdata[ValueW-1:0];
				REG_DISARM_DELAY:   disarm_delay_q   <= pwdata[DelayW-1:0];
				REG_DISARM_ANY_THR: disarm_any_thr_q <= pwdata[0];
				REG_AUTO_ARM:       auto_arm_q       <= pwdata[0];
				REG_PROFILE_EN:     profile_en_q     <= pwdata[0];
				REG_WAYPOINT_EN:    waypoint_en_q    <= pwdata[0];
				REG_MISSION_EN:     mission_en_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_LOW_THRESHOLD:  prdata = {{(DataW-ValueW){1'b0}}, low_threshold_q};
			REG_HIGH_THRESHOLD: prdata = {{(DataW-ValueW){1'b0}}, high_threshold_q};
			REG_DISARM_DELAY:   prdata = {{(DataW-DelayW){1'b0}}, disarm_delay_q};
			REG_DISARM_ANY_THR: prdata = {{(DataW-1){1'b0}}, disarm_any_thr_q};
			REG_AUTO_ARM:       prdata = {{(DataW-1){1'b0}}, auto_arm_q};
			REG_PROFILE_EN:     prdata = {{(DataW-1){1'b0}}, profile_en_q};
			REG_WAYPOINT_EN:    prdata = {{(DataW-1){1'b0}}, waypoint_en_q};
			REG_MISSION_EN:     prdata = {{(DataW-1){1'b0}}, mission_en_q};
			default:            prdata = '0;
		endcase
	end

	// ---------------- Handshake ----------------
	assign out_free     = !out_valid_q || !decode_stall;
	assign s1_free      = !valid_s1 || out_free;
	assign stick_stall  = !s1_free;
	assign process      = valid_s1 && out_free;
	assign decode_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= stick_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// ---------------- Stage one: axis lanes ----------------
	assign lane_value[0] = stick_data.roll_value;
	assign lane_value[1] = stick_data.pitch_value;
	assign lane_value[2] = stick_data.yaw_value;
	assign lane_value[3] = stick_data.throttle_value;

	for (genvar g = 0; g < NumAxes; g++) begin : g_lane
		rcsd_axis_lane u_lane (
			.clk            (clk),
			.load           (s1_free),
			.value          (lane_value[g]),
			.low_threshold  (low_threshold_q),
			.high_threshold (high_threshold_q),
			.axis_s1        (axis_s1[g])
		);
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			req_s1 <= stick_data;
		end
	end

	// ---------------- Stage two: merge and state update ----------------
	assign enables = '{profile_en: profile_en_q, waypoint_en: waypoint_en_q,
		mission_en: mission_en_q};

	rcsd_gesture_merge u_merge (
		.axis_s1 (axis_s1),
		.enables (enables),
		.pattern (pattern),
		.match   (match)
	);

	assign tick_elapsed   = req_s1.now_ms - last_tick_q;
	assign disarm_elapsed = req_s1.now_ms - disarm_mark_q;
	assign tick_due       = tick_elapsed >= TICK_MS;
	assign same_pattern   = pattern == prev_pattern_q;
	assign take_tick      = same_pattern && (hold_count_q < HOLD_MAX) && tick_due;

	always_comb begin
		if (!same_pattern) begin
			hold_mid = '0;
		end else if (take_tick) begin
			hold_mid = hold_count_q + CountW'(1);
		end else begin
			hold_mid = hold_count_q;
		end
	end

	assign auto_arm_mode = req_s1.plane_motorstop && auto_arm_q;

	always_comb begin
		arm_req      = 1'b0;
		disarm_req   = 1'b0;
		skip         = 1'b0;
		refresh_mark = 1'b0;
		if (auto_arm_mode) begin
			arm_req = !req_s1.throttle_at_low;
			skip    = !req_s1.throttle_at_low;
		end else if (req_s1.arm_switch_on) begin
			arm_req      = 1'b1;
			refresh_mark = 1'b1;
		end else if (req_s1.is_armed && req_s1.link_trusted) begin
			disarm_req = (disarm_elapsed > {{(TimeW-DelayW){1'b0}}, disarm_delay_q})
				&& (disarm_any_thr_q || req_s1.throttle_at_low);
		end else begin
			refresh_mark = 1'b1;
		end
	end

	assign gesture_fire = !skip && (hold_mid == GESTURE_HOLD) && !req_s1.is_armed
		&& !req_s1.menu_active && match.hit;

	// Mission steps restart the hold; trims drop it back so they repeat.
	always_comb begin
		hold_next = hold_mid;
		if (gesture_fire) begin
			case (match.hold)
				HOLD_CLEAR: hold_next = '0;
				HOLD_TEN:   hold_next = TRIM_HOLD;
				default:    hold_next = hold_mid;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pattern_q <= '0;
			hold_count_q   <= '0;
			last_tick_q    <= '0;
			disarm_mark_q  <= '0;
		end else if (process) begin
			prev_pattern_q <= pattern;
			hold_count_q   <= hold_next;
			if (take_tick) begin
				last_tick_q <= req_s1.now_ms;
			end
			if (refresh_mark) begin
				disarm_mark_q <= req_s1.now_ms;
			end
		end
	end

	assign rsp_d.stick_pattern  = pattern;
	assign rsp_d.arm_request    = arm_req;
	assign rsp_d.disarm_request = disarm_req;
	assign rsp_d.gesture_code   = gesture_fire ? match.code : GC_NONE;

	always_ff @(posedge clk) begin
		if (process) begin
			decode_data <= rsp_d;
		end
	end

endmodule

// ===== hdl/rcsd_axis_lane.sv =====
// One axis lane: classes a channel value against the two thresholds and
// registers the two class bits. Depends on rcsd_pkg.
module rcsd_axis_lane
	import rcsd_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic [ValueW-1:0] value,
	input  logic [ValueW-1:0] low_threshold,
	input  logic [ValueW-1:0] high_threshold,
	output logic [1:0]        axis_s1
);

	logic [1:0] axis_d;

	// Bit 1: above the low threshold; bit 0: below the high threshold.
	assign axis_d = {value > low_threshold, value < high_threshold};

	always_ff @(posedge clk) begin
		if (load) begin
			axis_s1 <= axis_d;
		end
	end

endmodule

// ===== hdl/rcsd_gesture_merge.sv =====
// Merging stage: joins the four lane results into the stick pattern and
// matches it against the gesture table with the enable gates. Depends on rcsd_pkg.
module rcsd_gesture_merge
	import rcsd_pkg::*;
(
	input  logic [1:0]          axis_s1 [NumAxes],
	input  gesture_enables_t    enables,
	output logic [PatternW-1:0] pattern,
	output gesture_hit_t        match
);

	gesture_entry_t entry;
	logic           gate_open;

	// Lane 0 is roll in the low bits, lane 3 throttle in the high bits.
	always_comb begin
		for (int i = 0; i < NumAxes; i++) begin
			pattern[2*i +: 2] = axis_s1[i];
		end
	end

	assign entry = gesture_lookup(pattern);

	always_comb begin
		unique case (entry.gate)
			GATE_WP:      gate_open = enables.waypoint_en;
			GATE_MISSION: gate_open = enables.waypoint_en & enables.mission_en;
			GATE_PROFILE: gate_open = enables.profile_en;
			default:      gate_open = 1'b1;
		endcase
	end

	assign match.hit  = (entry.code != GC_NONE) && gate_open;
	assign match.code = entry.code;
	assign match.hold = entry.hold;

endmodule

// ===== bench/tb_rc_stick_command_decoder.sv =====
// Self-checking bench for rc_stick_command_decoder: drives stick updates and APB
// register writes, predicts every decode result and compares it field by field.
// Depends on rcsd_pkg and the decoder RTL.
module tb_rc_stick_command_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import rcsd_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic             clk;
	logic             arst_n;
	logic             stick_valid;
	logic             stick_stall;
	stick_req_t       stick_data;
	logic             decode_valid;
	logic             decode_stall;
	decode_rsp_t      decode_data;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	rc_stick_command_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.stick_valid(stick_valid),
		.stick_stall(stick_stall),
		.stick_data(stick_data),
		.decode_valid(decode_valid),
		.decode_stall(decode_stall),
		.decode_data(decode_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Register copies, kept in step with every APB write.
	logic [ValueW-1:0] lo_thr       = LOW_THRESHOLD_RST;
	logic [ValueW-1:0] hi_thr       = HIGH_THRESHOLD_RST;
	logic [DelayW-1:0] disarm_delay = DISARM_DELAY_RST;
	logic              any_thr      = 1'b1;
	logic              auto_arm     = 1'b0;
	logic              prof_en      = 1'b0;
	logic              wp_en        = 1'b1;
	logic              mis_en       = 1'b1;

	// Decoder state as the predictor sees it.
	logic [PatternW-1:0] held_pattern   = '0;
	logic [CountW-1:0]   hold_ticks     = '0;
	logic [TimeW-1:0]    tick_mark_ms   = '0;
	logic [TimeW-1:0]    switch_mark_ms = '0;

	stick_req_t          stick_backlog[$];
	decode_rsp_t         awaited_decodes[$];
	logic [PatternW-1:0] gesture_pats[$];
	logic [TimeW-1:0]    clock_ms;

	logic req_taken = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;
	int   stall_mode = 0;
	int   stall_mode_left = 0;
	int   stall_run_left = 0;
	int   queued = 0;
	int   items_taken = 0;
	int   results_seen = 0;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   settings_used = 1;
	int   gestures_seen = 0;
	int   arm_seen = 0;
	int   disarm_seen = 0;
	logic [31:0] seen_codes = '0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic logic [1:0] axis_class(logic [ValueW-1:0] v);
		return {v > lo_thr, v < hi_thr};
	endfunction

	// Gesture table, patterns written throttle, yaw, pitch, roll.
	function automatic void table_entry(input logic [PatternW-1:0] p, output gesture_code_t code,
			output gate_t gate, output hold_action_t hold);
		code = GC_NONE;
		gate = GATE_NONE;
		hold = HOLD_KEEP;
		case (p)
			{AX_LO, AX_LO, AX_LO, AX_CE}: code = GC_GYRO_CAL;
			{AX_LO, AX_CE, AX_HI, AX_LO}: begin
				code = GC_WP_SAVE;
				gate = GATE_WP;
			end
			{AX_LO, AX_CE, AX_HI, AX_HI}: begin
				code = GC_WP_LOAD;
				gate = GATE_WP;
			end
			{AX_LO, AX_CE, AX_CE, AX_HI}: begin
				code = GC_MISSION_NEXT;
				gate = GATE_MISSION;
				hold = HOLD_CLEAR;
			end
			{AX_LO, AX_CE, AX_CE, AX_LO}: begin
				code = GC_MISSION_PREV;
				gate = GATE_MISSION;
				hold = HOLD_CLEAR;
			end
			{AX_LO, AX_CE, AX_LO, AX_HI}: begin
				code = GC_WP_RESET;
				gate = GATE_WP;
			end
			{AX_LO, AX_LO, AX_CE, AX_LO}: begin
				code = GC_CFG_PROFILE1;
				gate = GATE_PROFILE;
			end
			{AX_LO, AX_LO, AX_HI, AX_CE}: begin
				code = GC_CFG_PROFILE2;
				gate = GATE_PROFILE;
			end
			{AX_LO, AX_LO, AX_CE, AX_HI}: begin
				code = GC_CFG_PROFILE3;
				gate = GATE_PROFILE;
			end
			{AX_HI, AX_LO, AX_CE, AX_LO}: begin
				code = GC_BAT_PROFILE1;
				gate = GATE_PROFILE;
			end
			{AX_HI, AX_LO, AX_HI, AX_CE}: begin
				code = GC_BAT_PROFILE2;
				gate = GATE_PROFILE;
			end
			{AX_HI, AX_LO, AX_CE, AX_HI}: begin
				code = GC_BAT_PROFILE3;
				gate = GATE_PROFILE;
			end
			{AX_LO, AX_LO, AX_LO, AX_HI}: code = GC_SAVE;
			{AX_HI, AX_LO, AX_LO, AX_CE}: code = GC_ACC_CAL;
			{AX_HI, AX_HI, AX_LO, AX_CE}: code = GC_MAG_CAL;
			{AX_HI, AX_CE, AX_HI, AX_CE}: begin
				code = GC_TRIM_PITCH_HI;
				hold = HOLD_TEN;
			end
			{AX_HI, AX_CE, AX_LO, AX_CE}: begin
				code = GC_TRIM_PITCH_LO;
				hold = HOLD_TEN;
			end
			{AX_HI, AX_CE, AX_CE, AX_HI}: begin
				code = GC_TRIM_ROLL_HI;
				hold = HOLD_TEN;
			end
			{AX_HI, AX_CE, AX_CE, AX_LO}: begin
				code = GC_TRIM_ROLL_LO;
				hold = HOLD_TEN;
			end
			default: code = GC_NONE;
		endcase
	endfunction

	// Advances the predicted state by one stick update and returns its decode.
	function automatic decode_rsp_t decode_sticks(stick_req_t r);
		decode_rsp_t         rsp;
		logic [PatternW-1:0] p;
		logic [TimeW-1:0]    since_tick;
		logic [TimeW-1:0]    since_mark;
		logic                skip;
		logic                gate_ok;
		gesture_code_t       code;
		gate_t               gate;
		hold_action_t        hold;
		rsp = '0;
		skip = 1'b0;
		p = {axis_class(r.throttle_value), axis_class(r.yaw_value),
			axis_class(r.pitch_value), axis_class(r.roll_value)};
		since_tick = r.now_ms - tick_mark_ms;
		if (p == held_pattern) begin
			if (hold_ticks < HOLD_MAX && since_tick >= TICK_MS) begin
				tick_mark_ms = r.now_ms;
				hold_ticks++;
			end
		end else begin
			hold_ticks = '0;
		end
		held_pattern = p;

		if (r.plane_motorstop && auto_arm) begin
			// A low throttle on an auto-arm plane falls through to the gestures.
			if (!r.throttle_at_low) begin
				rsp.arm_request = 1'b1;
				skip = 1'b1;
			end
		end else if (r.arm_switch_on) begin
			switch_mark_ms = r.now_ms;
			rsp.arm_request = 1'b1;
		end else if (r.is_armed && r.link_trusted) begin
			since_mark = r.now_ms - switch_mark_ms;
			if (since_mark > {16'd0, disarm_delay} && (any_thr || r.throttle_at_low))
				rsp.disarm_request = 1'b1;
		end else begin
			switch_mark_ms = r.now_ms;
		end

		if (!skip && hold_ticks == GESTURE_HOLD && !r.is_armed && !r.menu_active) begin
			table_entry(p, code, gate, hold);
			case (gate)
				GATE_WP:      gate_ok = wp_en;
				GATE_MISSION: gate_ok = wp_en && mis_en;
				GATE_PROFILE: gate_ok = prof_en;
				default:      gate_ok = 1'b1;
			endcase
			if (code != GC_NONE && gate_ok) begin
				rsp.gesture_code = code;
				if (hold == HOLD_CLEAR)
					hold_ticks = '0;
				else if (hold == HOLD_TEN)
					hold_ticks = TRIM_HOLD;
			end
		end
		rsp.stick_pattern = p;
		return rsp;
	endfunction

	function automatic logic [DataW-1:0] cfg_readback(reg_index_t idx);
		case (idx)
			REG_LOW_THRESHOLD:  return {20'd0, lo_thr};
			REG_HIGH_THRESHOLD: return {20'd0, hi_thr};
			REG_DISARM_DELAY:   return {16'd0, disarm_delay};
			REG_DISARM_ANY_THR: return {31'd0, any_thr};
			REG_AUTO_ARM:       return {31'd0, auto_arm};
			REG_PROFILE_EN:     return {31'd0, prof_en};
			REG_WAYPOINT_EN:    return {31'd0, wp_en};
			default:            return {31'd0, mis_en};
		endcase
	endfunction

	// One APB write, then a read of the same register to check what was kept.
	task automatic reg_write_check(reg_index_t idx, logic [DataW-1:0] val);
		logic [DataW-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= AddrW'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_LOW_THRESHOLD:  lo_thr = val[ValueW-1:0];
			REG_HIGH_THRESHOLD: hi_thr = val[ValueW-1:0];
			REG_DISARM_DELAY:   disarm_delay = val[DelayW-1:0];
			REG_DISARM_ANY_THR: any_thr = val[0];
			REG_AUTO_ARM:       auto_arm = val[0];
			REG_PROFILE_EN:     prof_en = val[0];
			REG_WAYPOINT_EN:    wp_en = val[0];
			default:            mis_en = val[0];
		endcase
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== cfg_readback(idx))
			flag_mismatch($sformatf("register %s reads %h, expected %h", idx.name(), got,
				cfg_readback(idx)));
	endtask

	// Upper bits of the narrow registers get junk so that masking is exercised too.
	task automatic apply_setting(logic [ValueW-1:0] lo, logic [ValueW-1:0] hi,
			logic [DelayW-1:0] dly, logic [4:0] bits);
		reg_write_check(REG_LOW_THRESHOLD, {20'($urandom), lo});
		reg_write_check(REG_HIGH_THRESHOLD, {20'($urandom), hi});
		reg_write_check(REG_DISARM_DELAY, {16'($urandom), dly});
		reg_write_check(REG_DISARM_ANY_THR, {31'($urandom), bits[4]});
		reg_write_check(REG_AUTO_ARM, {31'($urandom), bits[3]});
		reg_write_check(REG_PROFILE_EN, {31'($urandom), bits[2]});
		reg_write_check(REG_WAYPOINT_EN, {31'($urandom), bits[1]});
		reg_write_check(REG_MISSION_EN, {31'($urandom), bits[0]});
		settings_used++;
	endtask

	task automatic wait_idle();
		while (stick_backlog.size() != 0 || stick_valid || awaited_decodes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A channel value that falls in the wanted class, often right on a threshold edge.
	function automatic logic [ValueW-1:0] value_for(axis_class_t c);
		int a;
		int b;
		case (c)
			AX_CE: begin
				a = int'(lo_thr) + 1;
				b = int'(hi_thr) - 1;
			end
			AX_LO: begin
				a = 0;
				b = (int'(lo_thr) < int'(hi_thr) - 1) ? int'(lo_thr) : int'(hi_thr) - 1;
			end
			AX_HI: begin
				a = (int'(lo_thr) + 1 > int'(hi_thr)) ? int'(lo_thr) + 1 : int'(hi_thr);
				b = 4095;
			end
			default: begin
				a = int'(hi_thr);
				b = int'(lo_thr);
			end
		endcase
		if (a > b || b < 0 || a > 4095)
			return 12'($urandom_range(4095, 0));
		case ($urandom_range(3, 0))
			0:       return 12'(a);
			1:       return 12'(b);
			default: return 12'($urandom_range(b, a));
		endcase
	endfunction

	function automatic logic [PatternW-1:0] pick_target();
		if ($urandom_range(3, 0) != 0)
			return gesture_pats[$urandom_range(gesture_pats.size() - 1, 0)];
		return 8'($urandom);
	endfunction

	// flags: plane, menu, armed, trusted, switch, throttle low
	task automatic queue_stick(logic [PatternW-1:0] target, int unsigned step, logic [5:0] flags);
		stick_req_t r;
		r.roll_value = value_for(axis_class_t'(target[1:0]));
		r.pitch_value = value_for(axis_class_t'(target[3:2]));
		r.yaw_value = value_for(axis_class_t'(target[5:4]));
		r.throttle_value = value_for(axis_class_t'(target[7:6]));
		clock_ms = clock_ms + step;
		r.now_ms = clock_ms;
		{r.plane_motorstop, r.menu_active, r.is_armed, r.link_trusted, r.arm_switch_on,
			r.throttle_at_low} = flags;
		stick_backlog.push_back(r);
		queued++;
	endtask

	// Sticks held in one pattern long enough for the hold count to reach a gesture.
	task automatic queue_hold_run(int reps, logic [PatternW-1:0] target);
		logic [5:0]  base;
		logic [5:0]  f;
		int unsigned step;
		base = {$urandom_range(3, 0) == 0, $urandom_range(7, 0) == 0, $urandom_range(5, 0) == 0,
			$urandom_range(3, 0) != 0, $urandom_range(3, 0) == 0, 1'($urandom)};
		for (int i = 0; i < reps; i++) begin
			f = base;
			for (int b = 0; b < 6; b++)
				if ($urandom_range(15, 0) == 0)
					f[b] = ~f[b];
			if (i == 0)
				step = $urandom_range(2000, 0);
			else if ($urandom_range(9, 0) == 0)
				step = $urandom_range(19, 0);
			else
				step = $urandom_range(40, 20);
			queue_stick(target, step, f);
		end
	endtask

	// Arm switch on for a while, then off with the craft armed, so the delay gets crossed.
	task automatic queue_arm_cycle(int reps);
		logic [PatternW-1:0] target;
		logic [5:0]          f;
		logic                plane;
		int                  on_items;
		int unsigned         step;
		target = 8'($urandom);
		plane = $urandom_range(5, 0) == 0;
		on_items = $urandom_range(reps - 1, 0);
		for (int i = 0; i < reps; i++) begin
			f = {plane, $urandom_range(7, 0) == 0, $urandom_range(7, 0) != 0,
				$urandom_range(5, 0) != 0, i < on_items, 1'($urandom)};
			case ($urandom_range(7, 0))
				0:       step = $urandom;
				1:       step = 0;
				default: step = $urandom_range(300, 1);
			endcase
			queue_stick(target, step, f);
		end
	endtask

	task automatic queue_noise(int n);
		stick_req_t r;
		repeat (n) begin
			r.roll_value = 12'($urandom);
			r.pitch_value = 12'($urandom);
			r.yaw_value = 12'($urandom);
			r.throttle_value = 12'($urandom);
			r.now_ms = ($urandom_range(1, 0) == 0) ? $urandom : clock_ms + $urandom_range(50, 0);
			{r.plane_motorstop, r.menu_active, r.is_armed, r.link_trusted, r.arm_switch_on,
				r.throttle_at_low} = 6'($urandom);
			stick_backlog.push_back(r);
			queued++;
		end
	endtask

	task automatic queue_phase(int budget);
		int start;
		start = queued;
		while (queued - start < budget) begin
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4, 5:
					queue_hold_run(($urandom_range(4, 0) == 0) ? $urandom_range(60, 30) :
						$urandom_range(28, 23), pick_target());
				6, 7:    queue_arm_cycle($urandom_range(16, 4));
				default: queue_noise($urandom_range(8, 1));
			endcase
		end
	endtask

	// Sender: bursts of requests with idle gaps in between, some bursts long.
	always @(negedge clk) begin : drive_sticks
		logic next_valid;
		if (arst_n) begin
			next_valid = stick_valid;
			if (!stick_valid || req_taken) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (stick_backlog.size() > 0) begin
					stick_data <= stick_backlog.pop_front();
					next_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(3, 0) == 0) begin
						gap_left = 0;
						burst_left = $urandom_range(120, 40);
					end else begin
						gap_left = $urandom_range(6, 1);
						burst_left = $urandom_range(30, 1);
					end
				end
			end
			stick_valid <= next_valid;
		end
	end

	// Receiver stall: free, light, heavy or in long on/off runs, switching now and then.
	always @(negedge clk) begin : drive_stall
		if (arst_n) begin
			if (stall_mode_left == 0) begin
				stall_mode <= $urandom_range(3, 0);
				stall_mode_left <= $urandom_range(300, 40);
			end else begin
				stall_mode_left <= stall_mode_left - 1;
			end
			case (stall_mode)
				0: decode_stall <= 1'b0;
				1: decode_stall <= $urandom_range(3, 0) == 0;
				2: decode_stall <= $urandom_range(3, 0) != 0;
				default: begin
					if (stall_run_left == 0) begin
						decode_stall <= ~decode_stall;
						stall_run_left <= $urandom_range(10, 1);
					end else begin
						stall_run_left <= stall_run_left - 1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin : watch_decodes
		decode_rsp_t want;
		if (arst_n) begin
			req_taken <= stick_valid && !stick_stall;
			if (decode_valid && !decode_stall) begin
				results_seen++;
				if (awaited_decodes.size() == 0) begin
					flag_mismatch($sformatf("result %0d (%h) arrived with nothing pending",
						results_seen, decode_data));
				end else begin
					want = awaited_decodes.pop_front();
					if (decode_data.stick_pattern !== want.stick_pattern)
						flag_mismatch($sformatf("result %0d stick_pattern %h, expected %h",
							results_seen, decode_data.stick_pattern, want.stick_pattern));
					if (decode_data.arm_request !== want.arm_request)
						flag_mismatch($sformatf("result %0d arm_request %b, expected %b",
							results_seen, decode_data.arm_request, want.arm_request));
					if (decode_data.disarm_request !== want.disarm_request)
						flag_mismatch($sformatf("result %0d disarm_request %b, expected %b",
							results_seen, decode_data.disarm_request, want.disarm_request));
					if (decode_data.gesture_code !== want.gesture_code)
						flag_mismatch($sformatf("result %0d gesture_code %0d, expected %0d",
							results_seen, decode_data.gesture_code, want.gesture_code));
					if (want.gesture_code != GC_NONE) begin
						gestures_seen++;
						seen_codes[want.gesture_code] <= 1'b1;
					end
					arm_seen += want.arm_request;
					disarm_seen += want.disarm_request;
				end
			end
			if (stick_valid && !stick_stall) begin
				items_taken++;
				awaited_decodes.push_back(decode_sticks(stick_data));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results still pending", cycle_count,
				awaited_decodes.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		stick_req_t    r;
		gesture_code_t c;
		gate_t         g;
		hold_action_t  h;
		arst_n = 1'b0;
		stick_valid = 1'b0;
		stick_data = '0;
		decode_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int p = 0; p < 256; p++) begin
			table_entry(8'(p), c, g, h);
			if (c != GC_NONE)
				gesture_pats.push_back(8'(p));
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, then a gyro calibration hold that wraps the ms clock.
		r = '0;
		stick_backlog.push_back(r);
		r.roll_value = '1;
		r.pitch_value = '1;
		r.yaw_value = '1;
		r.throttle_value = '1;
		r.now_ms = '1;
		{r.plane_motorstop, r.menu_active, r.is_armed, r.link_trusted, r.arm_switch_on,
			r.throttle_at_low} = '1;
		stick_backlog.push_back(r);
		queued = 2;
		clock_ms = 32'hFFFF_FF6C;
		repeat (22)
			queue_stick({AX_LO, AX_LO, AX_LO, AX_CE}, 20, 6'b000100);
		wait_idle();

		clock_ms = $urandom;
		apply_setting(12'd1100, 12'd1900, 16'd250, 5'b10111);
		// Pattern with no gesture held long enough to saturate the hold count.
		queue_hold_run(300, {AX_CE, AX_CE, AX_CE, AX_CE});
		queue_phase(200);
		wait_idle();
		apply_setting(12'd1000, 12'd2000, 16'd0, 5'b01110);
		queue_phase(200);
		wait_idle();
		apply_setting(12'd0, 12'd4095, 16'hFFFF, 5'b10001);
		queue_phase(200);
		wait_idle();
		// Crossed thresholds: every axis reads neither low, high nor centre.
		apply_setting(12'd4095, 12'd0, 16'd1, 5'b01100);
		queue_phase(60);
		wait_idle();
		apply_setting(12'd1500, 12'd1500, 16'd100, 5'b10111);
		queue_phase(150);
		wait_idle();
		begin : random_setting
			logic [ValueW-1:0] lo;
			lo = 12'($urandom_range(2000, 0));
			apply_setting(lo, lo + 12'($urandom_range(2000, 2)), 16'($urandom), 5'($urandom));
		end
		queue_phase(200);
		wait_idle();
		apply_setting(12'd1100, 12'd1900, 16'($urandom_range(400, 0)), {1'($urandom), 4'b1111});
		queue_phase(200);
		wait_idle();
		apply_setting(12'd1100, 12'd1900, 16'd250, 5'b10011);
		queue_phase(150);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Covered %0d stick updates under %0d register settings, each result checked.",
			items_taken, settings_used);
		$display("Saw %0d gestures over %0d distinct codes, %0d arm and %0d disarm requests.",
			gestures_seen, $countones(seen_codes), arm_seen, disarm_seen);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
